// ----- design/stt_pkg.sv -----
// ---------------------------------------------------------------------------
// stt_pkg
// Shared types, token kinds and keyword table for the source text tokenizer.
// ---------------------------------------------------------------------------
package stt_pkg;

    localparam int OFF_W      = 24;
    localparam int KW_CHARS   = 8;
    localparam int PREFIX_W   = KW_CHARS * 8;
    localparam int WCOUNT_W   = 4;
    localparam int KW_COUNT   = 15;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

    // token kinds
    localparam logic [5:0] KIND_EOF      = 6'd0;
    localparam logic [5:0] KIND_ID       = 6'd1;
    localparam logic [5:0] KIND_INT      = 6'd2;
    localparam logic [5:0] KIND_CHAR     = 6'd3;
    localparam logic [5:0] KIND_STR      = 6'd4;
    localparam logic [5:0] KIND_OROR     = 6'd5;
    localparam logic [5:0] KIND_ANDAND   = 6'd6;
    localparam logic [5:0] KIND_EQEQ     = 6'd7;
    localparam logic [5:0] KIND_PLUS     = 6'd8;
    localparam logic [5:0] KIND_MINUS    = 6'd9;
    localparam logic [5:0] KIND_STAR     = 6'd10;
    localparam logic [5:0] KIND_SLASH    = 6'd11;
    localparam logic [5:0] KIND_LPAREN   = 6'd12;
    localparam logic [5:0] KIND_LBRACK   = 6'd13;
    localparam logic [5:0] KIND_LBRACE   = 6'd14;
    localparam logic [5:0] KIND_RPAREN   = 6'd15;
    localparam logic [5:0] KIND_RBRACK   = 6'd16;
    localparam logic [5:0] KIND_RBRACE   = 6'd17;
    localparam logic [5:0] KIND_DEFINE   = 6'd18;
    localparam logic [5:0] KIND_COLON    = 6'd19;
    localparam logic [5:0] KIND_COMMA    = 6'd20;
    localparam logic [5:0] KIND_ASSIGN   = 6'd21;
    localparam logic [5:0] KIND_QUEST    = 6'd22;
    localparam logic [5:0] KIND_SEMI     = 6'd23;
    localparam logic [5:0] KIND_KW_FIRST = 6'd24;
    localparam logic [5:0] KIND_ERR      = 6'd39;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_CHAR  = 2'd1;
    localparam logic [1:0] ERR_OPEN_STR = 2'd2;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_WORD,
        MODE_NUMBER,
        MODE_STRING,
        MODE_CHARQ,
        MODE_BAR,
        MODE_AMP,
        MODE_EQ,
        MODE_COLON,
        MODE_SLASH,
        MODE_ERROR
    } mode_t;

    typedef struct packed {
        logic [5:0]       kind;
        logic [1:0]       err;
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] len;
        logic [7:0]       chr;
        logic             last;
    } result_t;

    // up to two results from one text byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } scan_out_t;

    // keyword text, first character in the top byte, zero padded
    localparam logic [PREFIX_W-1:0] KW_TXT [KW_COUNT] = '{
        {"void", 32'h0}, {"char", 32'h0}, {"bool", 32'h0}, {"int", 40'h0},
        {"print", 24'h0}, {"if", 48'h0}, {"then", 32'h0}, {"else", 32'h0},
        {"while", 24'h0}, {"do", 48'h0}, {"break", 24'h0}, {"continue"},
        {"return", 16'h0}, {"false", 24'h0}, {"true", 32'h0}
    };

    localparam logic [WCOUNT_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd4, 4'd4, 4'd3, 4'd5, 4'd2, 4'd4, 4'd4,
        4'd5, 4'd2, 4'd5, 4'd8, 4'd6, 4'd5, 4'd4
    };

    function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] x);
        return (x != OFF_MAX) ? x + 1'b1 : x;
    endfunction

    // kind of a finished word: keyword on exact match, identifier otherwise
    function automatic logic [5:0] word_kind(input logic [PREFIX_W-1:0] prefix,
                                             input logic [WCOUNT_W-1:0] count);
        logic [5:0] kind;
        logic       hit;
        kind = KIND_ID;
        hit  = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!hit && KW_LEN[i] == count && KW_TXT[i] == prefix) begin
                hit  = 1'b1;
                kind = KIND_KW_FIRST + 6'(i);
            end
        end
        return kind;
    endfunction

endpackage

// ----- design/stt_result_fifo.sv -----
// ---------------------------------------------------------------------------
// stt_result_fifo
// Four-entry token queue; takes up to two tokens a cycle, gives one unless the token side stalls.
// ---------------------------------------------------------------------------
module stt_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::scan_out_t scan_out,
    output logic               room,
    output logic               token_valid,
    input  logic               token_stall,
    output stt_pkg::result_t   token
);
    import stt_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 pop;
    logic [FIFO_AW-1:0]   wr_ptr_plus1;

    assign pop          = (count_reg != '0) && !token_stall;
    assign room         = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(scan_out.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(scan_out.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_out.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= scan_out.res0;
        end
        if (scan_out.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= scan_out.res1;
        end
    end

    assign token_valid = count_reg != '0;
    assign token       = mem_reg[rd_ptr_reg];

endmodule

// ----- design/stt_scan.sv -----
// ---------------------------------------------------------------------------
// stt_scan
// Byte register and scanner state; one text byte is scanned per cycle while the queue has room.
// ---------------------------------------------------------------------------
module stt_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_stall,
    input  logic [7:0]         text_byte,
    input  logic               room,
    output stt_pkg::scan_out_t scan_out
);
    import stt_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_BAR    = 8'h7c;

    typedef struct packed {
        mode_t   mode;
        logic    run;
        logic    word;
        logic    emit;
        logic    over;
        result_t res;
    } idle_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] kind;
    } op_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {[8'h61:8'h7a], [8'h41:8'h5a]});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
    endfunction

    function automatic result_t mk(input logic [5:0] kind, input logic [1:0] err,
                                   input logic [OFF_W-1:0] start,
                                   input logic [OFF_W-1:0] len,
                                   input logic [7:0] chr);
        result_t r;
        r.kind  = kind;
        r.err   = err;
        r.start = start;
        r.len   = len;
        r.chr   = chr;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic op_t single_op(input logic [7:0] b);
        op_t o;
        o.hit = 1'b1;
        case (b)
            8'h2b:   o.kind = KIND_PLUS;
            8'h2d:   o.kind = KIND_MINUS;
            8'h2a:   o.kind = KIND_STAR;
            8'h28:   o.kind = KIND_LPAREN;
            8'h5b:   o.kind = KIND_LBRACK;
            8'h7b:   o.kind = KIND_LBRACE;
            8'h29:   o.kind = KIND_RPAREN;
            8'h5d:   o.kind = KIND_RBRACK;
            8'h7d:   o.kind = KIND_RBRACE;
            8'h2c:   o.kind = KIND_COMMA;
            8'h3f:   o.kind = KIND_QUEST;
            8'h3b:   o.kind = KIND_SEMI;
            default:
            begin
                o.hit  = 1'b0;
                o.kind = KIND_ERR;
            end
        endcase
        return o;
    endfunction

    // scan of a byte met between tokens
    function automatic idle_t idle_scan(input logic [7:0] b, input logic [OFF_W-1:0] pos);
        idle_t r;
        op_t   o;
        o      = single_op(b);
        r.mode = MODE_IDLE;
        r.run  = 1'b1;
        r.word = 1'b0;
        r.emit = 1'b0;
        r.over = 1'b0;
        r.res  = mk(KIND_EOF, ERR_NONE, pos, '0, 8'h00);
        if (b == CH_NUL)
        begin
            r.emit = 1'b1;
            r.over = 1'b1;
        end
        else if (b inside {8'h20, [8'h09:8'h0d]})
        begin
            r.run = 1'b0;
        end
        else if (b == CH_SQUOTE)
        begin
            r.mode = MODE_CHARQ;
        end
        else if (b == CH_DQUOTE)
        begin
            r.mode = MODE_STRING;
        end
        else if (is_digit(b))
        begin
            r.mode = MODE_NUMBER;
        end
        else if (is_alpha(b))
        begin
            r.mode = MODE_WORD;
            r.word = 1'b1;
        end
        else if (b == CH_BAR)
        begin
            r.mode = MODE_BAR;
        end
        else if (b == CH_AMP)
        begin
            r.mode = MODE_AMP;
        end
        else if (b == CH_EQ)
        begin
            r.mode = MODE_EQ;
        end
        else if (b == CH_COLON)
        begin
            r.mode = MODE_COLON;
        end
        else if (b == CH_SLASH)
        begin
            r.mode = MODE_SLASH;
        end
        else if (o.hit)
        begin
            r.emit = 1'b1;
            r.res  = mk(o.kind, ERR_NONE, pos, OFF_W'(1), 8'h00);
        end
        else
        begin
            r.mode = MODE_ERROR;
            r.emit = 1'b1;
            r.res  = mk(KIND_ERR, ERR_BAD_CHAR, pos, '0, 8'h00);
        end
        return r;
    endfunction

    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    logic [7:0]            byte_reg;
    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [OFF_W-1:0]      pos_reg;
    logic [OFF_W-1:0]      pos_next;
    logic [OFF_W-1:0]      start_reg;
    logic [OFF_W-1:0]      start_next;
    logic [OFF_W-1:0]      run_reg;
    logic [OFF_W-1:0]      run_next;
    logic [PREFIX_W-1:0]   prefix_reg;
    logic [PREFIX_W-1:0]   prefix_next;
    logic [WCOUNT_W-1:0]   wcount_reg;
    logic [WCOUNT_W-1:0]   wcount_next;

    logic                  accept;
    logic                  fire;
    logic                  over;
    logic                  take_idle;
    logic                  pre_v;
    logic                  main_v;
    result_t               pre_res;
    result_t               main_res;
    idle_t                 idle;
    logic [OFF_W-1:0]      run_inc;
    logic [7:0]            b;

    assign b          = byte_reg;
    assign fire       = stage_valid_reg && room;
    assign text_stall = stage_valid_reg && !room;
    assign accept     = text_valid && !text_stall;
    assign idle       = idle_scan(byte_reg, pos_reg);
    assign run_inc    = sat_inc(run_reg);

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // next scan mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                mode_next = idle.mode;
            end
            MODE_COMMENT:
            begin
                if (b == CH_NUL)
                begin
                    mode_next = idle.mode;
                end
                else if (b == CH_NL)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_WORD:
            begin
                if (!is_word(b))
                begin
                    mode_next = idle.mode;
                end
            end
            MODE_NUMBER:
            begin
                if (!is_digit(b))
                begin
                    mode_next = idle.mode;
                end
            end
            MODE_STRING:
            begin
                if (b == CH_DQUOTE)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_CHARQ:
            begin
                mode_next = MODE_IDLE;
            end
            MODE_BAR:
            begin
                mode_next = (b == CH_BAR) ? MODE_IDLE : MODE_ERROR;
            end
            MODE_AMP:
            begin
                mode_next = (b == CH_AMP) ? MODE_IDLE : MODE_ERROR;
            end
            MODE_EQ, MODE_COLON:
            begin
                mode_next = (b == CH_EQ) ? MODE_IDLE : idle.mode;
            end
            MODE_SLASH:
            begin
                mode_next = (b == CH_SLASH) ? MODE_COMMENT : idle.mode;
            end
            MODE_ERROR:
            begin
                mode_next = MODE_ERROR;
            end
            default:
            begin
                mode_next = idle.mode;
            end
        endcase
        if (over)
        begin
            mode_next = MODE_IDLE;
        end
    end

    // token results and datapath state
    always_comb
    begin
        start_next  = start_reg;
        run_next    = run_reg;
        prefix_next = prefix_reg;
        wcount_next = wcount_reg;
        pre_v       = 1'b0;
        pre_res     = mk(KIND_EOF, ERR_NONE, '0, '0, 8'h00);
        main_v      = 1'b0;
        main_res    = mk(KIND_EOF, ERR_NONE, '0, '0, 8'h00);
        over        = 1'b0;
        take_idle   = 1'b0;
        case (mode_reg)
            MODE_IDLE:
            begin
                take_idle = 1'b1;
            end
            MODE_COMMENT:
            begin
                take_idle = (b == CH_NUL);
            end
            MODE_WORD:
            begin
                if (is_word(b))
                begin
                    for (int i = 0; i < KW_CHARS; i++)
                    begin
                        if (wcount_reg == WCOUNT_W'(i))
                        begin
                            prefix_next[PREFIX_W-1-8*i -: 8] = b;
                        end
                    end
                    if (wcount_reg <= WCOUNT_W'(KW_CHARS))
                    begin
                        wcount_next = wcount_reg + 1'b1;
                    end
                    run_next = run_inc;
                end
                else
                begin
                    pre_v     = 1'b1;
                    pre_res   = mk(word_kind(prefix_reg, wcount_reg), ERR_NONE,
                                   start_reg, run_reg, 8'h00);
                    take_idle = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(b))
                begin
                    run_next = run_inc;
                end
                else
                begin
                    pre_v     = 1'b1;
                    pre_res   = mk(KIND_INT, ERR_NONE, start_reg, run_reg, 8'h00);
                    take_idle = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (b == CH_NUL)
                begin
                    main_v   = 1'b1;
                    main_res = mk(KIND_ERR, ERR_OPEN_STR, start_reg, run_reg, 8'h00);
                    over     = 1'b1;
                end
                else
                begin
                    run_next = run_inc;
                    if (b == CH_DQUOTE)
                    begin
                        main_v   = 1'b1;
                        main_res = mk(KIND_STR, ERR_NONE, start_reg, run_inc, 8'h00);
                    end
                end
            end
            MODE_CHARQ:
            begin
                main_v = 1'b1;
                if (b == CH_NUL)
                begin
                    main_res = mk(KIND_ERR, ERR_NO_CHAR, start_reg, OFF_W'(1), 8'h00);
                    over     = 1'b1;
                end
                else
                begin
                    main_res = mk(KIND_CHAR, ERR_NONE, start_reg, OFF_W'(2), b);
                end
            end
            MODE_BAR, MODE_AMP:
            begin
                main_v = 1'b1;
                if (mode_reg == MODE_BAR && b == CH_BAR)
                begin
                    main_res = mk(KIND_OROR, ERR_NONE, start_reg, OFF_W'(2), 8'h00);
                end
                else if (mode_reg == MODE_AMP && b == CH_AMP)
                begin
                    main_res = mk(KIND_ANDAND, ERR_NONE, start_reg, OFF_W'(2), 8'h00);
                end
                else
                begin
                    // lone bar or ampersand
                    main_res = mk(KIND_ERR, ERR_BAD_CHAR, start_reg, OFF_W'(1), 8'h00);
                    over     = (b == CH_NUL);
                end
            end
            MODE_EQ, MODE_COLON:
            begin
                if (b == CH_EQ)
                begin
                    main_v   = 1'b1;
                    main_res = mk((mode_reg == MODE_EQ) ? KIND_EQEQ : KIND_DEFINE,
                                  ERR_NONE, start_reg, OFF_W'(2), 8'h00);
                end
                else
                begin
                    pre_v     = 1'b1;
                    pre_res   = mk((mode_reg == MODE_EQ) ? KIND_ASSIGN : KIND_COLON,
                                   ERR_NONE, start_reg, OFF_W'(1), 8'h00);
                    take_idle = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (b != CH_SLASH)
                begin
                    pre_v     = 1'b1;
                    pre_res   = mk(KIND_SLASH, ERR_NONE, start_reg, OFF_W'(1), 8'h00);
                    take_idle = 1'b1;
                end
            end
            MODE_ERROR:
            begin
                // sticky until end of text, no results
                over = (b == CH_NUL);
            end
            default:
            begin
                take_idle = 1'b1;
            end
        endcase

        if (take_idle)
        begin
            start_next = pos_reg;
            run_next   = OFF_W'(idle.run);
            main_v     = idle.emit;
            main_res   = idle.res;
            over       = idle.over;
            if (idle.word)
            begin
                prefix_next = {b, {(PREFIX_W-8){1'b0}}};
                wcount_next = WCOUNT_W'(1);
            end
        end

        pos_next = sat_inc(pos_reg);
        if (over)
        begin
            pos_next    = '0;
            start_next  = '0;
            run_next    = '0;
            prefix_next = '0;
            wcount_next = '0;
        end
    end

    // pack results in order, mark the final one
    always_comb
    begin
        scan_out.res0  = pre_v ? pre_res : main_res;
        scan_out.res1  = main_res;
        scan_out.count = 2'd0;
        if (fire)
        begin
            scan_out.count = 2'(pre_v) + 2'(main_v);
        end
        if (pre_v && main_v)
        begin
            scan_out.res1.last = 1'b1;
        end
        else
        begin
            scan_out.res0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            mode_reg        <= MODE_IDLE;
            pos_reg         <= '0;
            start_reg       <= '0;
            run_reg         <= '0;
            prefix_reg      <= '0;
            wcount_reg      <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (fire)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                start_reg  <= start_next;
                run_reg    <= run_next;
                prefix_reg <= prefix_next;
                wcount_reg <= wcount_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text_byte;
        end
    end

endmodule

// ----- design/source_text_tokenizer_core.sv -----
// ---------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming lexer: source bytes in, tokens with kind, offset and length out.
// ---------------------------------------------------------------------------
// Takes one text byte per cycle while the token queue has room and turns
// the text into tokens; byte zero ends the text, emits eof (or the error
// of an open string, char literal, lone bar or lone ampersand) and returns
// the lexer to its reset state. A byte is registered, then scanned against
// the scanner state (mode, offsets, the first eight characters of a word
// for the parallel keyword compare); its tokens are written into a
// four-entry queue once it has room, and are offered from the queue. The
// queue delivers one token per cycle while not stalled, so the sustained
// rate is one byte per cycle while bytes give at most one token each; a
// byte that both ends a held word, number or operator and yields a token
// of its own gives two tokens, delivered one at a time. After an error,
// bytes are consumed silently until end of text.
module source_text_tokenizer_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      text_valid,
    output logic                      text_stall,
    input  logic [7:0]                text_byte,
    output logic                      token_valid,
    input  logic                      token_stall,
    output logic [5:0]                token_kind,
    output logic [1:0]                error_code,
    output logic [stt_pkg::OFF_W-1:0] token_start,
    output logic [stt_pkg::OFF_W-1:0] token_length,
    output logic [7:0]                char_value,
    output logic                      last_of_run
);
    import stt_pkg::*;

    scan_out_t scan_out;
    result_t   token;
    logic      room;

    stt_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_byte  (text_byte),
        .room       (room),
        .scan_out   (scan_out)
    );

    stt_result_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .scan_out    (scan_out),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token)
    );

    assign token_kind   = token.kind;
    assign error_code   = token.err;
    assign token_start  = token.start;
    assign token_length = token.len;
    assign char_value   = token.chr;
    assign last_of_run  = token.last;

endmodule

// ----- dv/tb_source_text_tokenizer_core.sv -----
// ---------------------------------------------------------------------------
// tb_source_text_tokenizer_core
// Byte-stream testbench for the tokenizer: short directed texts, then random
// token sequences under several idle/stall mixes and one long output hold.
// Every accepted byte runs through a local lexer model and each token that
// comes out is checked field by field against the oldest predicted token.
// ---------------------------------------------------------------------------
module tb_source_text_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int KEYWORD_SPAN = KW_CHARS;
    localparam logic [7:0] NL = 8'h0A;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              text_valid = 1'b0;
    logic              text_stall;
    logic [7:0]        text_byte = 8'h00;
    logic              token_valid;
    logic              token_stall = 1'b0;
    logic [5:0]        token_kind;
    logic [1:0]        error_code;
    logic [OFF_W-1:0]  token_start;
    logic [OFF_W-1:0]  token_length;
    logic [7:0]        char_value;
    logic              last_of_run;

    source_text_tokenizer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .error_code   (error_code),
        .token_start  (token_start),
        .token_length (token_length),
        .char_value   (char_value),
        .last_of_run  (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    string kw_words [15] = '{"void", "char", "bool", "int", "print", "if", "then", "else",
                             "while", "do", "break", "continue", "return", "false", "true"};
    string op_words [19] = '{"||", "&&", "==", "+", "-", "*", "/", "(", "[", "{", ")", "]",
                             "}", ":=", ":", ",", "=", "?", ";"};

    // lexer model state
    mode_t             lex_mode;
    logic [OFF_W-1:0]  lex_pos;
    logic [OFF_W-1:0]  tok_start;
    logic [OFF_W-1:0]  tok_len;
    logic [7:0]        word_buf [KEYWORD_SPAN];
    logic [3:0]        word_cnt;
    bit                text_done;

    result_t           step_tokens [$];
    result_t           pending_tokens [$];
    logic [7:0]        text_buf [$];

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       bytes_sent = 0;
    int unsigned       mismatch_count = 0;
    logic              hold_on = 1'b0;

    function automatic logic [OFF_W-1:0] bump(input logic [OFF_W-1:0] x);
        return x + {{(OFF_W-1){1'b0}}, ~&x};
    endfunction

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_word_char(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == "_";
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic void lexer_clear();
        lex_mode  = MODE_IDLE;
        lex_pos   = '0;
        tok_start = '0;
        tok_len   = '0;
        word_cnt  = '0;
        foreach (word_buf[i])
            word_buf[i] = 8'h00;
    endfunction

    function automatic void emit_token(input logic [5:0] kind, input logic [1:0] err,
                                       input logic [OFF_W-1:0] st,
                                       input logic [OFF_W-1:0] ln, input logic [7:0] ch);
        result_t r;
        r.kind  = kind;
        r.err   = err;
        r.start = st;
        r.len   = ln;
        r.chr   = ch;
        r.last  = 1'b0;
        step_tokens.push_back(r);
    endfunction

    function automatic void raise_error(input logic [1:0] code, input logic [OFF_W-1:0] st,
                                        input logic [OFF_W-1:0] ln);
        emit_token(KIND_ERR, code, st, ln, 8'h00);
        lex_mode = MODE_ERROR;
    endfunction

    // single-byte operators that need no lookahead; KIND_ERR when none
    function automatic logic [5:0] op_kind(input logic [7:0] b);
        case (b)
            "+": return KIND_PLUS;
            "-": return KIND_MINUS;
            "*": return KIND_STAR;
            "(": return KIND_LPAREN;
            "[": return KIND_LBRACK;
            "{": return KIND_LBRACE;
            ")": return KIND_RPAREN;
            "]": return KIND_RBRACK;
            "}": return KIND_RBRACE;
            ",": return KIND_COMMA;
            "?": return KIND_QUEST;
            ";": return KIND_SEMI;
            default: return KIND_ERR;
        endcase
    endfunction

    function automatic logic [5:0] classify_word();
        logic [5:0] kind;
        bit         same;
        kind = KIND_ID;
        if (word_cnt <= KEYWORD_SPAN)
        begin
            foreach (kw_words[i])
            begin
                if (kw_words[i].len() == word_cnt)
                begin
                    same = 1'b1;
                    for (int j = 0; j < word_cnt; j++)
                        if (word_buf[j] != kw_words[i][j])
                            same = 1'b0;
                    if (same)
                        kind = KIND_KW_FIRST + 6'(i);
                end
            end
        end
        return kind;
    endfunction

    function automatic void scan_fresh(input logic [7:0] b);
        logic [5:0] op;
        op        = op_kind(b);
        lex_mode  = MODE_IDLE;
        tok_start = lex_pos;
        tok_len   = 1;
        if (b == 8'h00)
        begin
            emit_token(KIND_EOF, ERR_NONE, lex_pos, '0, 8'h00);
            text_done = 1'b1;
        end
        else if (is_space(b))
            tok_len = '0;
        else if (b == "'")
            lex_mode = MODE_CHARQ;
        else if (b == "\"")
            lex_mode = MODE_STRING;
        else if (is_digit(b))
            lex_mode = MODE_NUMBER;
        else if (is_alpha(b))
        begin
            lex_mode = MODE_WORD;
            foreach (word_buf[i])
                word_buf[i] = 8'h00;
            word_buf[0] = b;
            word_cnt    = 1;
        end
        else if (b == "|")
            lex_mode = MODE_BAR;
        else if (b == "&")
            lex_mode = MODE_AMP;
        else if (b == "=")
            lex_mode = MODE_EQ;
        else if (b == ":")
            lex_mode = MODE_COLON;
        else if (b == "/")
            lex_mode = MODE_SLASH;
        else if (op != KIND_ERR)
            emit_token(op, ERR_NONE, lex_pos, 1, 8'h00);
        else
            raise_error(ERR_BAD_CHAR, lex_pos, '0);
    endfunction

    function automatic void pair_or_single(input logic [7:0] b, input logic [5:0] pair,
                                           input logic [5:0] single);
        if (b == "=")
        begin
            emit_token(pair, ERR_NONE, tok_start, 2, 8'h00);
            lex_mode = MODE_IDLE;
        end
        else
        begin
            emit_token(single, ERR_NONE, tok_start, 1, 8'h00);
            scan_fresh(b);
        end
    endfunction

    // advance the model by one accepted byte and queue the tokens it yields
    function automatic void lex_byte(input logic [7:0] b);
        step_tokens.delete();
        text_done = 1'b0;
        case (lex_mode)
            MODE_COMMENT:
                if (b == 8'h00)
                    scan_fresh(b);
                else if (b == NL)
                    lex_mode = MODE_IDLE;
            MODE_WORD:
                if (b != 8'h00 && is_word_char(b))
                begin
                    if (word_cnt < KEYWORD_SPAN)
                        word_buf[word_cnt] = b;
                    if (word_cnt <= KEYWORD_SPAN)
                        word_cnt++;
                    tok_len = bump(tok_len);
                end
                else
                begin
                    emit_token(classify_word(), ERR_NONE, tok_start, tok_len, 8'h00);
                    scan_fresh(b);
                end
            MODE_NUMBER:
                if (is_digit(b))
                    tok_len = bump(tok_len);
                else
                begin
                    emit_token(KIND_INT, ERR_NONE, tok_start, tok_len, 8'h00);
                    scan_fresh(b);
                end
            MODE_STRING:
                if (b == 8'h00)
                begin
                    raise_error(ERR_OPEN_STR, tok_start, tok_len);
                    text_done = 1'b1;
                end
                else
                begin
                    tok_len = bump(tok_len);
                    if (b == "\"")
                    begin
                        emit_token(KIND_STR, ERR_NONE, tok_start, tok_len, 8'h00);
                        lex_mode = MODE_IDLE;
                    end
                end
            MODE_CHARQ:
                if (b == 8'h00)
                begin
                    raise_error(ERR_NO_CHAR, tok_start, 1);
                    text_done = 1'b1;
                end
                else
                begin
                    emit_token(KIND_CHAR, ERR_NONE, tok_start, 2, b);
                    lex_mode = MODE_IDLE;
                end
            MODE_BAR, MODE_AMP:
                if (b == ((lex_mode == MODE_BAR) ? "|" : "&"))
                begin
                    emit_token((lex_mode == MODE_BAR) ? KIND_OROR : KIND_ANDAND, ERR_NONE,
                               tok_start, 2, 8'h00);
                    lex_mode = MODE_IDLE;
                end
                else
                begin
                    raise_error(ERR_BAD_CHAR, tok_start, 1);
                    if (b == 8'h00)
                        text_done = 1'b1;
                end
            MODE_EQ:
                pair_or_single(b, KIND_EQEQ, KIND_ASSIGN);
            MODE_COLON:
                pair_or_single(b, KIND_DEFINE, KIND_COLON);
            MODE_SLASH:
                if (b == "/")
                    lex_mode = MODE_COMMENT;
                else
                begin
                    emit_token(KIND_SLASH, ERR_NONE, tok_start, 1, 8'h00);
                    scan_fresh(b);
                end
            MODE_ERROR:
                if (b == 8'h00)
                    text_done = 1'b1;
            default:
                scan_fresh(b);
        endcase

        if (text_done)
            lexer_clear();
        else
            lex_pos = bump(lex_pos);

        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
    endfunction

    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void check_token();
        result_t want;
        bit      ok;
        if (pending_tokens.size() == 0)
        begin
            $error("unexpected token: kind %0d start %0d", token_kind, token_start);
            mismatch_count++;
            return;
        end
        want = pending_tokens.pop_front();
        ok = field_ok("token_kind", 32'(want.kind), 32'(token_kind));
        ok &= field_ok("error_code", 32'(want.err), 32'(error_code));
        ok &= field_ok("token_start", 32'(want.start), 32'(token_start));
        ok &= field_ok("token_length", 32'(want.len), 32'(token_length));
        ok &= field_ok("char_value", 32'(want.chr), 32'(char_value));
        ok &= field_ok("last_of_run", 32'(want.last), 32'(last_of_run));
        if (!ok)
            mismatch_count++;
    endfunction

    // token side: check what was taken at this edge, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && token_valid && !token_stall)
            check_token();
        token_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        lex_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i]);
        text_buf.delete();
    endtask

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 52)
            return rand_alpha();
        else if (r < 62)
            return 8'("0" + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 8'(" ") : 8'(8 + r);
    endfunction

    // mostly well-formed token runs; some noise bytes and broken endings
    function automatic void gen_text();
        int         n_tok;
        int         pick;
        logic [7:0] c;
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
            begin
                add_str(kw_words[$urandom_range(0, 14)]);
                if ($urandom_range(0, 3) == 0)
                    text_buf.push_back(rand_word_char());
            end
            else if (pick < 4)
            begin
                text_buf.push_back(rand_alpha());
                repeat ($urandom_range(0, 11))
                    text_buf.push_back(rand_word_char());
            end
            else if (pick == 4)
            begin
                repeat ($urandom_range(1, 6))
                    text_buf.push_back(8'("0" + $urandom_range(0, 9)));
            end
            else if (pick == 5)
            begin
                add_str("\"");
                repeat ($urandom_range(0, 5))
                begin
                    do
                        c = 8'($urandom_range(1, 255));
                    while (c == "\"");
                    text_buf.push_back(c);
                end
                add_str("\"");
            end
            else if (pick == 6)
            begin
                add_str("'");
                text_buf.push_back(8'($urandom_range(1, 255)));
            end
            else if (pick < 11)
                add_str(op_words[$urandom_range(0, 18)]);
            else if (pick == 11)
            begin
                add_str("//");
                repeat ($urandom_range(0, 4))
                begin
                    do
                        c = 8'($urandom_range(1, 255));
                    while (c == NL);
                    text_buf.push_back(c);
                end
                text_buf.push_back(NL);
            end
            else if (pick == 12)
                text_buf.push_back(8'($urandom_range(1, 255)));
            else
            begin
                repeat ($urandom_range(1, 3))
                    text_buf.push_back(rand_space());
            end
            if ($urandom_range(0, 1) == 0)
                text_buf.push_back(rand_space());
        end

        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0: add_str("\"x");
                1: add_str("'");
                2: add_str("|");
                default: add_str("&");
            endcase
            text_buf.push_back(8'h00);
        end
        else if (pick != 1)
            text_buf.push_back(8'h00);
    endfunction

    task automatic run_random(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned n_bytes);
        int unsigned target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            gen_text();
            send_text();
        end
    endtask

    // == and := over their single forms, flushes by the next byte, lone bar at end
    task automatic test_operator_pairs();
        add_str("a==b:c:=/|");
        text_buf.push_back(8'h00);
        send_text();
    endtask

    // char literal leaves its closing quote, empty string, open literals at end
    task automatic test_literals();
        add_str("'a'9\"\"");
        text_buf.push_back(8'h00);
        add_str("\"x");
        text_buf.push_back(8'h00);
        add_str("'");
        text_buf.push_back(8'h00);
        send_text();
    endtask

    task automatic test_words_comments();
        add_str("//\nif_\tdo+");
        text_buf.push_back(8'h00);
        send_text();
    endtask

    // bad bytes, sticky error swallowing the rest, lone ampersand
    task automatic test_bad_bytes();
        text_buf = '{8'hFF, 8'h01, 8'h00, 8'h80, 8'h00, "&", "x", 8'h00};
        send_text();
    endtask

    task automatic test_no_idle();
        run_random(0, 0, 90);
    endtask

    task automatic test_sender_gaps();
        run_random(47, 0, 90);
    endtask

    task automatic test_receiver_stalls();
        run_random(0, 47, 90);
    endtask

    task automatic test_both_idle();
        run_random(6, 6, 90);
    endtask

    // hold the token side long enough for the block to fill and stall its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (300) @(posedge clk);
                hold_on <= 1'b0;
            end
            begin
                while (text_buf.size() < 60)
                    gen_text();
                send_text();
            end
        join
    endtask

    initial
    begin
        lexer_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operator_pairs();
        test_literals();
        test_words_comments();
        test_bad_bytes();
        test_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();

        // flush anything still held
        send_byte(8'h00);
        text_valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatch_count == 0)
            $display("source_text_tokenizer_core: match");
        else
            $display("source_text_tokenizer_core: mismatch");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("source_text_tokenizer_core: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
design/stt_pkg.sv
design/stt_result_fifo.sv
design/stt_scan.sv
design/source_text_tokenizer_core.sv
dv/tb_source_text_tokenizer_core.sv
